// ----- rtl/g6ce_pkg.sv -----
// shared types, constants and helpers of the graph6 character encoder
`default_nettype none

package g6ce_pkg;

  // field and bus widths
  localparam int VALUE_W         = 36;
  localparam int CHAR_W          = 7;
  localparam int CFG_W           = 6;
  localparam int MAX_VALUE_WIDTH = 32;
  localparam int PEND_W          = 5;
  localparam int PCNT_W          = 3;
  localparam int MAX_CHARS       = 8;
  localparam int CNT_W           = 4;
  localparam int IDX_W           = 3;
  localparam int GROUP_W         = 6;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  // register map
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;
  localparam logic REG_VALUE_WIDTH = 1'b0;
  localparam logic [CFG_W-1:0] VALUE_WIDTH_RESET = 6'd1;

  // item commands
  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_PACK   = 1'b1;

  // character codes and header limits
  localparam logic [CHAR_W-1:0]  CHAR_OFFSET  = 7'd63;
  localparam logic [CHAR_W-1:0]  ESCAPE_CHAR  = 7'd126;
  localparam logic [VALUE_W-1:0] SHORT_LIMIT  = 36'd62;
  localparam logic [VALUE_W-1:0] MEDIUM_LIMIT = 36'd258047;

  // one queued job: the characters one item causes
  typedef struct packed {
    logic [CNT_W-1:0]                  count;
    logic [MAX_CHARS-1:0][CHAR_W-1:0]  chars;
  } job_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // 6-bit group to printable character
  function automatic logic [CHAR_W-1:0] group_char(input logic [GROUP_W-1:0] g);
    group_char = {1'b0, g} + CHAR_OFFSET;
  endfunction

  // number of whole 6-bit groups in a bit count of at most 37
  function automatic logic [IDX_W-1:0] groups_of(input logic [5:0] total);
    if (total >= 6'd36) begin
      groups_of = 3'd6;
    end else if (total >= 6'd30) begin
      groups_of = 3'd5;
    end else if (total >= 6'd24) begin
      groups_of = 3'd4;
    end else if (total >= 6'd18) begin
      groups_of = 3'd3;
    end else if (total >= 6'd12) begin
      groups_of = 3'd2;
    end else if (total >= 6'd6) begin
      groups_of = 3'd1;
    end else begin
      groups_of = 3'd0;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/g6ce_front.sv -----
// front: accepts items, keeps the pending bits and builds the character job
`default_nettype none

module g6ce_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          item_valid_i,
  output logic                         item_ready_o,
  input  wire                          command_i,
  input  wire  [g6ce_pkg::VALUE_W-1:0] value_i,
  input  wire  [g6ce_pkg::CFG_W-1:0]   value_width_i,
  input  g6ce_pkg::fifo_stat_t         fifo_stat_i,
  output logic                         push_o,
  output g6ce_pkg::job_t               job_o
);
  import g6ce_pkg::*;

  logic [PEND_W-1:0] pend_bits_q, pend_bits_d;
  logic [PCNT_W-1:0] pend_cnt_q, pend_cnt_d;

  logic              accept;
  logic [5:0]        w_eff;
  logic [32:0]       vmask;
  logic [31:0]       vm;
  logic [36:0]       comb;
  logic [5:0]        total;
  logic [41:0]       al;
  logic [IDX_W-1:0]  ngroups;
  logic [5:0]        rem6;
  logic [PCNT_W-1:0] rem;
  job_t              hdr_job, pack_job;

  assign item_ready_o = !fifo_stat_i.full;
  assign accept       = item_valid_i && item_ready_o;

  // pack path: merge pending bits with the masked value, left-align the result
  always_comb begin
    if (value_width_i > 6'(MAX_VALUE_WIDTH)) begin
      w_eff = 6'(MAX_VALUE_WIDTH);
    end else begin
      w_eff = value_width_i;
    end
    vmask   = (33'd1 << w_eff) - 33'd1;
    vm      = value_i[31:0] & vmask[31:0];
    comb    = ({32'd0, pend_bits_q} << w_eff) | {5'd0, vm};
    total   = {3'd0, pend_cnt_q} + w_eff;
    al      = {comb, 5'd0} << (6'd37 - total);
    ngroups = groups_of(total);
    rem6    = total - ({3'd0, ngroups} << 2) - ({3'd0, ngroups} << 1);
    rem     = rem6[PCNT_W-1:0];
  end

  // pack job: one character per completed group, most significant first
  always_comb begin
    pack_job       = '0;
    pack_job.count = {1'b0, ngroups};
    for (int k = 0; k < 6; k++) begin
      pack_job.chars[k] = group_char(al[41-6*k -: 6]);
    end
  end

  // header job: short, medium or long form
  always_comb begin
    hdr_job = '0;
    if (value_i <= SHORT_LIMIT) begin
      hdr_job.count    = 4'd1;
      hdr_job.chars[0] = value_i[6:0] + CHAR_OFFSET;
    end else if (value_i <= MEDIUM_LIMIT) begin
      hdr_job.count    = 4'd4;
      hdr_job.chars[0] = ESCAPE_CHAR;
      hdr_job.chars[1] = group_char(value_i[17:12]);
      hdr_job.chars[2] = group_char(value_i[11:6]);
      hdr_job.chars[3] = group_char(value_i[5:0]);
    end else begin
      hdr_job.count    = 4'd8;
      hdr_job.chars[0] = ESCAPE_CHAR;
      hdr_job.chars[1] = ESCAPE_CHAR;
      for (int k = 0; k < 6; k++) begin
        hdr_job.chars[2+k] = group_char(value_i[35-6*k -: 6]);
      end
    end
  end

  // job select and push; items that cause no character are dropped here
  always_comb begin
    if (command_i == CMD_PACK) begin
      job_o = pack_job;
    end else begin
      job_o = hdr_job;
    end
    push_o = accept && (job_o.count != '0);
  end

  // pending bits advance on every accepted pack item
  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (accept && command_i == CMD_PACK) begin
      pend_bits_d = comb[PEND_W-1:0] & ((5'd1 << rem) - 5'd1);
      pend_cnt_d  = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/g6ce_fifo.sv -----
// short job queue between the front and the back
`default_nettype none

module g6ce_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  g6ce_pkg::job_t       push_job_i,
  input  wire                  pop_i,
  output g6ce_pkg::job_t       head_o,
  output g6ce_pkg::fifo_stat_t stat_o
);
  import g6ce_pkg::*;

  job_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W:0]   fill_q, fill_d;
  logic                  do_push, do_pop;

  assign stat_o.full  = (fill_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/g6ce_back.sv -----
// back: plays out the characters of each job, one per cycle while the receiver is ready
`default_nettype none

module g6ce_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  g6ce_pkg::fifo_stat_t        fifo_stat_i,
  input  g6ce_pkg::job_t              head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [g6ce_pkg::CHAR_W-1:0] character_o,
  output logic                        last_o
);
  import g6ce_pkg::*;

  job_t             cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             busy_q, busy_d;
  logic             fire;

  assign out_valid_o = busy_q;
  assign character_o = cur_q.chars[idx_q];
  assign last_o      = ({1'b0, idx_q} == (cur_q.count - 4'd1));
  assign fire        = busy_q && out_ready_i;

  // step through the current job, take the next one without a gap when the queue holds one
  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    pop_o  = 1'b0;
    if (!busy_q || (fire && last_o)) begin
      if (!fifo_stat_i.empty) begin
        pop_o  = 1'b1;
        cur_d  = head_i;
        idx_d  = '0;
        busy_d = 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end else if (fire) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  // job payload
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

`default_nettype wire

// ----- rtl/graph6_character_encoder.sv -----
// Top level of the graph6 / sparse6 printable character encoder.
// Input stream: s_axis_tuser selects the command (header number or pack),
// s_axis_tdata carries the 36-bit value. Each item is accepted when
// s_axis_tvalid and s_axis_tready are high, one item per cycle while the
// four-entry job queue has room.
// Output stream: one character per cycle on m_axis_tdata while m_axis_tready
// is high; m_axis_tlast marks the final character an item causes. A header
// item gives 1, 4 or 8 characters, a pack item 0 to 6; the output serializer
// sets the rate. The first character of an item passes through the job queue
// and then the back's current-job register before it appears on the output.
// A stalled receiver holds the current character; the front keeps taking
// items until the queue is full, then drops s_axis_tready.
// APB: register value_width at address 0 (reset 1). Write only while idle.
// Reset clears the pending bits, the queue and the output; it is
// asynchronous and takes effect at once, with no clearing pass.
`default_nettype none

module graph6_character_encoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  // slave stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // [35:0] value, [39:36] zero
  input  wire         s_axis_tuser,   // [0] command
  // master stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] character, [7] zero
  output logic        m_axis_tlast,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [g6ce_pkg::PADDR_W-1:0] paddr,
  input  wire  [g6ce_pkg::PDATA_W-1:0] pwdata,
  output logic [g6ce_pkg::PDATA_W-1:0] prdata,
  output logic        pready
);
  import g6ce_pkg::*;

  logic [CFG_W-1:0]  value_width_q, value_width_d;
  logic              cfg_wr;
  fifo_stat_t        fifo_stat;
  job_t              push_job, head_job;
  logic              push, pop;
  logic [CHAR_W-1:0] character;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_VALUE_WIDTH);

  always_comb begin
    value_width_d = value_width_q;
    if (cfg_wr) begin
      value_width_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_width_q <= VALUE_WIDTH_RESET;
    end else begin
      value_width_q <= value_width_d;
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == REG_VALUE_WIDTH) begin
      prdata = {{(PDATA_W-CFG_W){1'b0}}, value_width_q};
    end else begin
      prdata = '0;
    end
  end

  g6ce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (s_axis_tvalid),
    .item_ready_o  (s_axis_tready),
    .command_i     (s_axis_tuser),
    .value_i       (s_axis_tdata[VALUE_W-1:0]),
    .value_width_i (value_width_q),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .job_o         (push_job)
  );

  g6ce_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .stat_o     (fifo_stat)
  );

  g6ce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .character_o (character),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, character};

endmodule

`default_nettype wire

// ----- rtl/g6ce_checker.sv -----
// port-level checks of the graph6 character encoder, bound to the top level
`default_nettype none

module g6ce_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [7:0]  m_axis_tdata,
  input wire        m_axis_tlast
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output character changed while stalled");

  // every character is printable within the code range
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >= 8'd63) && (m_axis_tdata <= 8'd126))
    else $error("output character out of range");

  // the front only stalls when the back holds work
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with idle output");

  // the characters of one item follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside the characters of one item");

endmodule

bind graph6_character_encoder g6ce_checker u_g6ce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
